// ----- src/ofp_pkg.sv -----
// ofp_pkg: types, constants and helpers for the optical flow frame parser
// no dependencies; used by ofp_front, ofp_queue, ofp_back and the top level
package ofp_pkg;

   localparam int ACC_WIDTH = 32;
   localparam int OUT_WIDTH = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] HDR_FIRST = 8'hFE;
   localparam logic [7:0] HDR_SECOND = 8'h04;
   localparam logic [7:0] TAIL_A = 8'hAA;
   localparam logic [7:0] TAIL_B = 8'hBB;
   localparam logic [3:0] FIRST_PAYLOAD_INDEX = 4'd2;
   localparam logic [3:0] TAIL_INDEX = 4'd8;

   localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH - 1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH - 1){1'b0}}};

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_HDR_SECOND,
      PH_PAYLOAD
   } phase_type;

   typedef enum logic {
      REQ_BYTE  = 1'b0,
      REQ_CLEAR = 1'b1
   } req_kind_type;

   typedef enum logic {
      CMD_FRAME,
      CMD_CLEAR
   } cmd_kind_type;

   // one entry of the queue between parser and accumulator
   typedef struct packed {
      cmd_kind_type kind;
      logic frame_ok;
      logic [15:0] raw_x;
      logic [15:0] raw_y;
      logic [7:0] quality;
   } cmd_type;

   function automatic logic signed [ACC_WIDTH-1:0] sat_add(
      input logic signed [ACC_WIDTH-1:0] acc,
      input logic signed [15:0] delta
   );
      logic signed [ACC_WIDTH:0] s;
      s = (ACC_WIDTH + 1)'(acc) + (ACC_WIDTH + 1)'(delta);
      if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
         return s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
      end
      return s[ACC_WIDTH-1:0];
   endfunction

   // low output bits of an integral, sign-extended when the integral is narrower
   function automatic logic [OUT_WIDTH-1:0] acc_out(input logic signed [ACC_WIDTH-1:0] acc);
      logic signed [63:0] w;
      w = 64'(acc);
      return w[OUT_WIDTH-1:0];
   endfunction

endpackage

// ----- src/ofp_front.sv -----
// ofp_front: byte parser, hunts for the header and assembles frames
// depends on ofp_pkg; pushes frame and clear commands into ofp_queue
module ofp_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  logic            in_kind,
   input  logic [7:0]      in_byte,
   output logic            push_valid,
   input  logic            push_ready,
   output ofp_pkg::cmd_type push_cmd
);

   ofp_pkg::phase_type phase_ff, phase_in;
   logic [3:0] index_ff, index_in;
   logic [7:0] frame_ff [2:7];
   logic accept;
   logic is_clear;
   logic last_byte;
   logic [7:0] cksum;
   logic tail_ok;

   assign in_ready = push_ready;
   assign accept = in_valid & push_ready;
   assign is_clear = (in_kind == ofp_pkg::REQ_CLEAR);
   assign last_byte = (phase_ff == ofp_pkg::PH_PAYLOAD) && (index_ff == ofp_pkg::TAIL_INDEX);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ofp_pkg::PH_HUNT;
         index_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         index_ff <= index_in;
      end
   end

   // payload bytes, no reset needed
   always_ff @(posedge clock) begin
      if (accept && !is_clear && phase_ff == ofp_pkg::PH_PAYLOAD && !last_byte) begin
         frame_ff[index_ff[2:0]] <= in_byte;
      end
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      index_in = index_ff;
      if (accept && !is_clear) begin
         case (phase_ff)
            ofp_pkg::PH_HUNT: begin
               if (in_byte == ofp_pkg::HDR_FIRST) begin
                  phase_in = ofp_pkg::PH_HDR_SECOND;
                  index_in = 4'd1;
               end
            end
            ofp_pkg::PH_HDR_SECOND: begin
               // a wrong second byte is not retried as a first header byte
               if (in_byte == ofp_pkg::HDR_SECOND) begin
                  phase_in = ofp_pkg::PH_PAYLOAD;
                  index_in = ofp_pkg::FIRST_PAYLOAD_INDEX;
               end else begin
                  phase_in = ofp_pkg::PH_HUNT;
                  index_in = '0;
               end
            end
            ofp_pkg::PH_PAYLOAD: begin
               if (last_byte) begin
                  phase_in = ofp_pkg::PH_HUNT;
                  index_in = '0;
               end else begin
                  index_in = index_ff + 4'd1;
               end
            end
            default: begin
               phase_in = ofp_pkg::PH_HUNT;
               index_in = '0;
            end
         endcase
      end
   end

   // outputs
   assign cksum = frame_ff[2] + frame_ff[3] + frame_ff[4] + frame_ff[5];
   assign tail_ok = (in_byte == ofp_pkg::TAIL_A) || (in_byte == ofp_pkg::TAIL_B);

   always_comb begin
      push_valid = in_valid && (is_clear || last_byte);
      push_cmd.kind = is_clear ? ofp_pkg::CMD_CLEAR : ofp_pkg::CMD_FRAME;
      push_cmd.frame_ok = (cksum == frame_ff[6]) && tail_ok;
      push_cmd.raw_x = {frame_ff[3], frame_ff[2]};
      push_cmd.raw_y = {frame_ff[5], frame_ff[4]};
      push_cmd.quality = frame_ff[7];
   end

endmodule

// ----- src/ofp_queue.sv -----
// ofp_queue: short command queue between the parser and the accumulator
// depends on ofp_pkg for the entry type and depth
module ofp_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            wr_valid,
   output logic            wr_ready,
   input  ofp_pkg::cmd_type wr_cmd,
   output logic            rd_valid,
   input  logic            rd_ready,
   output ofp_pkg::cmd_type rd_cmd
);

   ofp_pkg::cmd_type store_ff [ofp_pkg::QUEUE_DEPTH];
   logic [ofp_pkg::QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ofp_pkg::QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ofp_pkg::QCNT_WIDTH-1:0] count_ff, count_in;
   logic push;
   logic pop;

   assign wr_ready = (count_ff != ofp_pkg::QCNT_WIDTH'(ofp_pkg::QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign push = wr_valid & wr_ready;
   assign pop = rd_valid & rd_ready;
   assign rd_cmd = store_ff[rd_ptr_ff];

   function automatic logic [ofp_pkg::QPTR_WIDTH-1:0] next_ptr(
      input logic [ofp_pkg::QPTR_WIDTH-1:0] p
   );
      if (p == ofp_pkg::QPTR_WIDTH'(ofp_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

// ----- src/ofp_back.sv -----
// ofp_back: applies commands to the integrals and counters, holds the result register
// depends on ofp_pkg for the command type and saturating add
module ofp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  ofp_pkg::cmd_type cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output logic             out_ok,
   output logic [167:0]     out_data
);

   logic signed [ofp_pkg::ACC_WIDTH-1:0] sum_fwd_ff, sum_fwd_in;
   logic signed [ofp_pkg::ACC_WIDTH-1:0] sum_right_ff, sum_right_in;
   logic [31:0] good_ff, good_in;
   logic [31:0] bad_ff, bad_in;
   logic valid_ff, valid_in;
   logic ok_ff;
   logic [15:0] fwd_ff, fwd_in;
   logic [15:0] right_ff, right_in;
   logic [7:0] qual_ff, qual_in;
   logic take;
   logic is_clear;
   logic [15:0] neg_x;

   assign is_clear = (cmd.kind == ofp_pkg::CMD_CLEAR);
   // clears wait as well, the integrals feed the waiting result
   assign cmd_ready = !valid_ff || out_ready;
   assign take = cmd_valid & cmd_ready;
   assign neg_x = 16'd0 - cmd.raw_x;

   always_comb begin
      sum_fwd_in = sum_fwd_ff;
      sum_right_in = sum_right_ff;
      good_in = good_ff;
      bad_in = bad_ff;
      valid_in = valid_ff && !out_ready;
      fwd_in = '0;
      right_in = '0;
      qual_in = '0;
      if (take) begin
         if (is_clear) begin
            sum_fwd_in = '0;
            sum_right_in = '0;
         end else begin
            valid_in = 1'b1;
            if (cmd.frame_ok) begin
               fwd_in = cmd.raw_y;
               right_in = neg_x;
               qual_in = cmd.quality;
               sum_fwd_in = ofp_pkg::sat_add(sum_fwd_ff, cmd.raw_y);
               sum_right_in = ofp_pkg::sat_add(sum_right_ff, neg_x);
               good_in = good_ff + 32'd1;
            end else begin
               bad_in = bad_ff + 32'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_fwd_ff <= '0;
         sum_right_ff <= '0;
         good_ff <= '0;
         bad_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         sum_fwd_ff <= sum_fwd_in;
         sum_right_ff <= sum_right_in;
         good_ff <= good_in;
         bad_ff <= bad_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && !is_clear) begin
         ok_ff <= cmd.frame_ok;
         fwd_ff <= fwd_in;
         right_ff <= right_in;
         qual_ff <= qual_in;
      end
   end

   // counters and integrals stay put while a result waits, so they are read live
   assign out_valid = valid_ff;
   assign out_ok = ok_ff;
   assign out_data = {bad_ff, good_ff, ofp_pkg::acc_out(sum_right_ff),
                      ofp_pkg::acc_out(sum_fwd_ff), qual_ff, right_ff, fwd_ff};

endmodule

// ----- src/optical_flow_frame_parser.sv -----
// channel   dir  handshake                 payload
// req_      in   req_tvalid / req_tready   tuser: req_type, tdata: rx_byte
// rsp_      out  rsp_tvalid / rsp_tready   tuser: frame_ok, tdata: flows, integrals, counts
//
// one byte accepted per cycle while req_tready is high; a frame result passes through the
// queue, then the result register, and clear requests travel the same queue in order
// reset is synchronous and zeroes integrals, counters and parser state
// req_tready drops only when the two-entry queue fills behind a stalled rsp_ side
//
// optical_flow_frame_parser: top level; depends on ofp_pkg, ofp_front, ofp_queue, ofp_back
module optical_flow_frame_parser (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,  // [7:0] rx_byte
   input  logic         req_tuser,  // [0] req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [167:0] rsp_tdata,  // [15:0] flow_fwd, [31:16] flow_right, [39:32] quality,
                                    // [71:40] integral_fwd, [103:72] integral_right,
                                    // [135:104] good_frames, [167:136] bad_frames
   output logic         rsp_tuser   // [0] frame_ok
);

   logic push_valid;
   logic push_ready;
   ofp_pkg::cmd_type push_cmd;
   logic pop_valid;
   logic pop_ready;
   ofp_pkg::cmd_type pop_cmd;

   ofp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_kind    (req_tuser),
      .in_byte    (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   ofp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_cmd   (push_cmd),
      .rd_valid (pop_valid),
      .rd_ready (pop_ready),
      .rd_cmd   (pop_cmd)
   );

   ofp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .cmd       (pop_cmd),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_ok    (rsp_tuser),
      .out_data  (rsp_tdata)
   );

endmodule

// ----- src/ofp_checker.sv -----
// ofp_checker: port-level assertions for optical_flow_frame_parser
// no package dependency; bound to the top level below
module ofp_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [7:0]   req_tdata,
   input logic         req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [167:0] rsp_tdata,
   input logic         rsp_tuser
);

   // a stalled result transaction keeps its contents
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   // a rejected frame reports zero flow and quality
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[39:0] == 40'd0)
      else $error("rejected frame carries flow data");

   // an offered result is fully defined
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !$isunknown({rsp_tuser, rsp_tdata}))
      else $error("result carries unknown bits");

endmodule

bind optical_flow_frame_parser ofp_checker u_ofp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
